// File: hw/rtl/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// TLB page table translator package
// Field widths of the translation ports and default sizes of the TLB, the
// page table and the physical frame pool.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    // Fixed widths of the port fields.
    localparam int VA_W = 16;
    localparam int PA_W = 15;
    localparam int FN_W = 7;

    // Default sizes. Entry, page and byte counts are powers of two.
    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int FRAME_COUNT_DEF = 128;
    localparam int PAGE_BYTES_DEF  = 256;

endpackage

// File: hw/rtl/tlb_page_table_translator_unit.sv
// ----------------------------------------------------------------------------
// TLB page table translator
// Translates virtual addresses to physical addresses through a TLB backed by
// a page table that allocates frames on demand.
// ----------------------------------------------------------------------------
// The unit accepts one virtual address per cycle while the output side is
// ready, and returns one result per address. An accepted address is
// registered as the page table memory is read; from the input stage the TLB
// is searched, the page table answer is checked, a frame is allocated on a
// page fault, the TLB is refilled under its FIFO pointer and the result
// register is loaded. A page-table write made in the same cycle as the next
// address's read is forwarded around the memory, so back-to-back addresses
// on the same page translate correctly. After reset the page table is
// cleared one entry per cycle, and no address transfer is taken during that
// pass. When every frame is in use, a fault reports frames_exhausted with a
// zero frame and address, and nothing is allocated or cached.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_unit #(
    parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF,
    parameter int FRAME_COUNT = tlbpt_pkg::FRAME_COUNT_DEF,
    parameter int PAGE_BYTES  = tlbpt_pkg::PAGE_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [tlbpt_pkg::VA_W-1:0] i_virtual_address,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [tlbpt_pkg::PA_W-1:0] o_physical_address,
    output logic [tlbpt_pkg::FN_W-1:0] o_frame_number,
    output logic                       o_tlb_hit,
    output logic                       o_page_fault,
    output logic                       o_frames_exhausted
);

    import tlbpt_pkg::*;

    localparam int OFF_W = $clog2(PAGE_BYTES);
    localparam int PG_W  = $clog2(PAGE_COUNT);
    localparam int FR_W  = $clog2(FRAME_COUNT);
    localparam int NF_W  = $clog2(FRAME_COUNT + 1);
    localparam int ENT_W = FR_W + 1;

    // Input stage.
    logic                r_s1_valid;
    logic [VA_W-1:0]     r_va;

    // Page table clearing pass.
    logic                r_clr_busy;
    logic [PG_W-1:0]     r_clr_addr;

    // Last page-table write, used to forward around the memory read.
    logic                r_wr_valid;
    logic [PG_W-1:0]     r_wr_page;
    logic [FR_W-1:0]     r_wr_frame;

    logic [NF_W-1:0]     r_next_free;

    // Result register.
    logic                r_out_valid;
    logic [PA_W-1:0]     r_pa;
    logic [FN_W-1:0]     r_fn;
    logic                r_hit;
    logic                r_fault;
    logic                r_exhausted;

    logic                accept;
    logic                s1_adv;
    logic [VA_W+PG_W-1:0] in_va_ext;
    logic [VA_W+PG_W-1:0] s1_va_ext;
    logic [PG_W-1:0]     in_page;
    logic [PG_W-1:0]     s1_page;
    logic [OFF_W-1:0]    s1_offset;

    logic                tlb_hit;
    logic [FR_W-1:0]     tlb_frame;
    logic                tlb_fill;

    logic [ENT_W-1:0]    pt_rd_data;
    logic                pt_wr_en;
    logic [PG_W-1:0]     pt_wr_addr;
    logic [ENT_W-1:0]    pt_wr_data;
    logic                pt_present;
    logic [FR_W-1:0]     pt_frame;

    logic                can_alloc;
    logic                have_frame;
    logic                fault;
    logic                exhausted;
    logic [FR_W-1:0]     frame;
    logic [FR_W+OFF_W+PA_W-1:0] pa_ext;
    logic [FR_W+FN_W-1:0] fn_ext;

    // The input stage moves on when the result register is free or drains.
    assign s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign accept  = i_valid && o_ready;

    // Page number is the address divided by the page size, modulo the page
    // count; zero padding keeps the slice legal for the largest page size.
    assign in_va_ext = {{PG_W{1'b0}}, i_virtual_address};
    assign in_page   = in_va_ext[OFF_W +: PG_W];
    assign s1_va_ext = {{PG_W{1'b0}}, r_va};
    assign s1_page   = s1_va_ext[OFF_W +: PG_W];
    assign s1_offset = r_va[OFF_W-1:0];

    tlbpt_tlb #(
        .ENTRIES (TLB_ENTRIES),
        .PAGE_W  (PG_W),
        .FRAME_W (FR_W)
    ) u_tlb (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_lookup_page (s1_page),
        .o_hit         (tlb_hit),
        .o_frame       (tlb_frame),
        .i_fill_en     (tlb_fill),
        .i_fill_frame  (frame)
    );

    // Each page-table word holds a present bit above the frame number.
    tlbpt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (PAGE_COUNT)
    ) u_page_table (
        .i_clk     (i_clk),
        .i_wr_en   (pt_wr_en),
        .i_wr_addr (pt_wr_addr),
        .i_wr_data (pt_wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (in_page),
        .o_rd_data (pt_rd_data)
    );

    // The memory misses only a write made at the edge of its own read, and
    // that write is always the most recent one, so forwarding the last write
    // on a page match is always correct.
    always_comb begin
        if (r_wr_valid && (r_wr_page == s1_page)) begin
            pt_present = 1'b1;
            pt_frame   = r_wr_frame;
        end else begin
            pt_present = pt_rd_data[FR_W];
            pt_frame   = pt_rd_data[FR_W-1:0];
        end
    end

    assign can_alloc  = r_next_free < NF_W'(FRAME_COUNT);
    assign have_frame = tlb_hit || pt_present || can_alloc;
    assign fault      = !tlb_hit && !pt_present && can_alloc;
    assign exhausted  = !tlb_hit && !pt_present && !can_alloc;
    assign tlb_fill   = s1_adv && !tlb_hit && have_frame;

    always_comb begin
        if (tlb_hit) begin
            frame = tlb_frame;
        end else if (pt_present) begin
            frame = pt_frame;
        end else begin
            frame = r_next_free[FR_W-1:0];
        end
    end

    // The clearing pass owns the write port until it is done.
    always_comb begin
        if (r_clr_busy) begin
            pt_wr_en   = 1'b1;
            pt_wr_addr = r_clr_addr;
            pt_wr_data = '0;
        end else begin
            pt_wr_en   = s1_adv && fault;
            pt_wr_addr = s1_page;
            pt_wr_data = {1'b1, frame};
        end
    end

    // Physical address is frame times page size plus offset, kept to the
    // port width.
    assign pa_ext = {{PA_W{1'b0}}, frame, s1_offset};
    assign fn_ext = {{FN_W{1'b0}}, frame};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_wr_valid  <= 1'b0;
            r_next_free <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (r_clr_busy) begin
                if (r_clr_addr == PG_W'(PAGE_COUNT - 1)) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end

            if (s1_adv && fault) begin
                r_wr_valid  <= 1'b1;
                r_next_free <= r_next_free + 1'b1;
            end

            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_va <= i_virtual_address;
        end
        if (s1_adv && fault) begin
            r_wr_page  <= s1_page;
            r_wr_frame <= frame;
        end
        if (s1_adv) begin
            r_pa        <= have_frame ? pa_ext[PA_W-1:0] : '0;
            r_fn        <= have_frame ? fn_ext[FN_W-1:0] : '0;
            r_hit       <= tlb_hit;
            r_fault     <= fault;
            r_exhausted <= exhausted;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_physical_address = r_pa;
    assign o_frame_number     = r_fn;
    assign o_tlb_hit          = r_hit;
    assign o_page_fault       = r_fault;
    assign o_frames_exhausted = r_exhausted;

    // A valid result never carries both fault and exhaustion, nor both hit and fault.
    a_fault_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_page_fault && o_frames_exhausted) && !(o_tlb_hit && o_page_fault))
        else $error("fault flags overlap");

    // Exhaustion reports a zero translation.
    a_exhaust_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frames_exhausted |-> (o_physical_address == '0) && (o_frame_number == '0))
        else $error("exhausted result carries a frame");

    // The frame counter never passes the pool size.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= NF_W'(FRAME_COUNT))
        else $error("frame counter overran");

    // A fault allocates exactly one frame.
    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && fault |=> r_next_free == $past(r_next_free) + 1'b1)
        else $error("fault did not allocate one frame");

    // No address is taken while the page table is being cleared.
    a_clr_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_ready && !r_s1_valid)
        else $error("transfer during page table clear");

endmodule

// File: hw/rtl/tlbpt_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. A read of the address being
// written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/tlbpt_tlb.sv
// ----------------------------------------------------------------------------
// Fully associative TLB with FIFO replacement
// Compares the lookup page against every valid entry in parallel; the lowest
// matching index wins. A fill writes the slot under the FIFO pointer.
// ----------------------------------------------------------------------------
module tlbpt_tlb #(
    parameter int ENTRIES = 16,
    parameter int PAGE_W  = 8,
    parameter int FRAME_W = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [PAGE_W-1:0]  i_lookup_page,
    output logic               o_hit,
    output logic [FRAME_W-1:0] o_frame,
    input  logic               i_fill_en,
    input  logic [FRAME_W-1:0] i_fill_frame
);

    localparam int SLOT_W = $clog2(ENTRIES);

    logic [ENTRIES-1:0] r_valid;
    logic [PAGE_W-1:0]  r_page  [ENTRIES];
    logic [FRAME_W-1:0] r_frame [ENTRIES];
    logic [SLOT_W-1:0]  r_fill_slot;
    logic [SLOT_W-1:0]  n_fill_slot;

    // Scan from the top down so that the lowest matching entry is kept.
    always_comb begin
        o_hit   = 1'b0;
        o_frame = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_page[i] == i_lookup_page)) begin
                o_hit   = 1'b1;
                o_frame = r_frame[i];
            end
        end
    end

    always_comb begin
        if (r_fill_slot == SLOT_W'(ENTRIES - 1)) begin
            n_fill_slot = '0;
        end else begin
            n_fill_slot = r_fill_slot + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_fill_slot <= '0;
        end else if (i_fill_en) begin
            r_valid[r_fill_slot] <= 1'b1;
            r_fill_slot          <= n_fill_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fill_en) begin
            r_page[r_fill_slot]  <= i_lookup_page;
            r_frame[r_fill_slot] <= i_fill_frame;
        end
    end

endmodule

// File: tb/tlb_page_table_translator_unit_tb.sv
// ----------------------------------------------------------------------------
// TLB page table translator testbench
// Drives virtual addresses through the valid/ready input channel and checks
// every result, field by field, against a directed row's fixed answer or a
// cycle-free model of the TLB, its FIFO refill pointer and the demand-allocating page table.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_unit_tb;

    localparam int VA_W        = tlbpt_pkg::VA_W;
    localparam int PA_W        = tlbpt_pkg::PA_W;
    localparam int FN_W        = tlbpt_pkg::FN_W;
    localparam int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF;
    localparam int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF;
    localparam int FRAME_COUNT = tlbpt_pkg::FRAME_COUNT_DEF;
    localparam int PAGE_BYTES  = tlbpt_pkg::PAGE_BYTES_DEF;

    // Random part of the run, the quiet tail with no idling, and the pauses.
    localparam int RANDOM_ITEMS = 500;
    localparam int QUIET_ITEMS  = 80;
    localparam int DRAIN_AT     = 250;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 60;
    localparam int SETTLE       = 10;
    // The clearing pass after reset takes no transfer, so the limit on idle
    // cycles is set well above its length.
    localparam int STALL_LIMIT  = 2000;
    localparam int PRINT_LIMIT  = 40;

    // One translation result, in port order.
    typedef struct packed {
        logic [PA_W-1:0] physical_address;
        logic [FN_W-1:0] frame_number;
        logic            tlb_hit;
        logic            page_fault;
        logic            frames_exhausted;
    } t_xlat;

    // One directed stimulus row. When fixed is set, the expected result is
    // taken from the row instead of from the translation model.
    typedef struct packed {
        logic [VA_W-1:0] va;
        logic            fixed;
        t_xlat           result;
    } t_addr_row;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_ready;
    logic [VA_W-1:0] i_virtual_address;
    logic            o_valid;
    logic            i_ready;
    logic [PA_W-1:0] o_physical_address;
    logic [FN_W-1:0] o_frame_number;
    logic            o_tlb_hit;
    logic            o_page_fault;
    logic            o_frames_exhausted;

    // Side information that travels with the address currently offered.
    logic  row_fixed;
    t_xlat row_result;

    // Model state: TLB contents, FIFO refill pointer and page table.
    bit                   cached_valid [TLB_ENTRIES];
    int unsigned          cached_page  [TLB_ENTRIES];
    int unsigned          cached_frame [TLB_ENTRIES];
    int unsigned          refill_slot;
    bit                   mapped       [PAGE_COUNT];
    int unsigned          mapped_frame [PAGE_COUNT];
    int unsigned          frames_used;

    t_xlat       pending_xlat [$];
    t_xlat       observed;
    int          mismatches;
    int          results_checked;
    int          idle_cycles;
    bit          quiet_tail;
    t_addr_row   directed_rows [$];

    tlb_page_table_translator_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_virtual_address  (i_virtual_address),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_physical_address (o_physical_address),
        .o_frame_number     (o_frame_number),
        .o_tlb_hit          (o_tlb_hit),
        .o_page_fault       (o_page_fault),
        .o_frames_exhausted (o_frames_exhausted)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Translates one address and advances the model state. The TLB is
    // searched in index order, so the lowest matching valid entry wins. A
    // miss falls back to the page table, and an absent page takes the next
    // free frame. Every miss that yields a frame refills the TLB slot under
    // the FIFO pointer. With no frame left, the result is all zero apart from
    // the exhaustion flag and nothing changes.
    function automatic t_xlat translate_address(input logic [VA_W-1:0] va);
        int unsigned page;
        int unsigned offset;
        int unsigned frame;
        bit          hit;
        bit          have_frame;
        t_xlat       res;
        page       = (int'(va) / PAGE_BYTES) % PAGE_COUNT;
        offset     = int'(va) % PAGE_BYTES;
        frame      = 0;
        hit        = 1'b0;
        have_frame = 1'b0;
        res        = '0;
        for (int s = 0; s < TLB_ENTRIES; s++) begin
            if (!hit && cached_valid[s] && cached_page[s] == page) begin
                hit        = 1'b1;
                have_frame = 1'b1;
                frame      = cached_frame[s];
            end
        end
        if (!hit) begin
            if (mapped[page]) begin
                frame      = mapped_frame[page];
                have_frame = 1'b1;
            end else if (frames_used < FRAME_COUNT) begin
                frame              = frames_used;
                frames_used        = frames_used + 1;
                mapped[page]       = 1'b1;
                mapped_frame[page] = frame;
                res.page_fault     = 1'b1;
                have_frame         = 1'b1;
            end else begin
                res.frames_exhausted = 1'b1;
            end
            if (have_frame) begin
                cached_valid[refill_slot] = 1'b1;
                cached_page[refill_slot]  = page;
                cached_frame[refill_slot] = frame;
                refill_slot               = (refill_slot + 1) % TLB_ENTRIES;
            end
        end
        if (have_frame) begin
            res.physical_address = PA_W'(frame * PAGE_BYTES + offset);
            res.frame_number     = FN_W'(frame);
        end
        res.tlb_hit = hit;
        return res;
    endfunction

    function automatic t_addr_row addr_row(input logic [VA_W-1:0] va, input logic fixed,
                                           input logic [PA_W-1:0] pa,
                                           input logic [FN_W-1:0] fn,
                                           input logic hit, input logic fault);
        t_addr_row r;
        r.va                      = va;
        r.fixed                   = fixed;
        r.result.physical_address = pa;
        r.result.frame_number     = fn;
        r.result.tlb_hit          = hit;
        r.result.page_fault       = fault;
        r.result.frames_exhausted = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT) begin
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        mismatches++;
    endtask

    task automatic check_result(input t_xlat got);
        t_xlat want;
        if (pending_xlat.size() == 0) begin
            report_mismatch("result with nothing pending", got.physical_address, 0);
            return;
        end
        want = pending_xlat.pop_front();
        if (got.physical_address != want.physical_address)
            report_mismatch("physical_address", got.physical_address, want.physical_address);
        if (got.frame_number != want.frame_number)
            report_mismatch("frame_number", got.frame_number, want.frame_number);
        if (got.tlb_hit != want.tlb_hit)
            report_mismatch("tlb_hit", got.tlb_hit, want.tlb_hit);
        if (got.page_fault != want.page_fault)
            report_mismatch("page_fault", got.page_fault, want.page_fault);
        if (got.frames_exhausted != want.frames_exhausted)
            report_mismatch("frames_exhausted", got.frames_exhausted, want.frames_exhausted);
    endtask

    // Offers one address and returns at the edge of its transfer. The valid
    // may drop for a short random gap first, but once raised it stays high
    // with the same address until the block takes it.
    task automatic offer_address(input logic [VA_W-1:0] va, input logic fixed,
                                 input t_xlat result);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_virtual_address <= va;
        row_fixed         <= fixed;
        row_result        <= result;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Lowers valid and waits until every outstanding translation has come
    // back. The first edge lets the model record the last transfer.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_xlat.size() != 0) @(posedge i_clk);
    endtask

    // Both channels are sampled at the rising edge, before any of this edge's
    // updates land, so a transfer is seen exactly where the block sees it.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            if (row_fixed) begin
                // Keep the model in step even when the row supplies the answer.
                void'(translate_address(i_virtual_address));
                pending_xlat.push_back(row_result);
            end else begin
                pending_xlat.push_back(translate_address(i_virtual_address));
            end
        end
        if (i_rst_n && o_valid && i_ready) begin
            observed.physical_address = o_physical_address;
            observed.frame_number     = o_frame_number;
            observed.tlb_hit          = o_tlb_hit;
            observed.page_fault       = o_page_fault;
            observed.frames_exhausted = o_frames_exhausted;
            check_result(observed);
            results_checked++;
        end
    end

    // Watchdog: any cycle with no transfer on either channel counts toward
    // the limit, and any transfer restarts the count.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver side. Ready runs high for random stretches with short stalls
    // between them. Once, after enough results, it holds off for a long
    // stretch while the sender keeps offering, so the pipeline fills up and
    // the block has to drop its input ready.
    initial begin
        bit held_once;
        held_once = 1'b0;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_once && results_checked >= HOLD_AFTER) begin
                held_once = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Sender side and end of run.
    initial begin
        logic [7:0]      hot_pages [24];
        int              hot_count;
        logic [VA_W-1:0] va;
        mismatches      = 0;
        results_checked = 0;
        idle_cycles     = 0;
        quiet_tail      = 1'b0;
        hot_count       = 0;
        i_rst_n           <= 1'b0;
        i_valid           <= 1'b0;
        i_virtual_address <= '0;
        row_fixed         <= 1'b0;
        row_result        <= '0;

        // Directed rows. Fixed answers are given where the allocation order
        // makes them obvious: first touches take frames 0, 1, 2, 3 in turn.
        directed_rows.push_back(addr_row(16'h0000, 1'b1, 15'h0000, 7'd0, 1'b0, 1'b1));
        directed_rows.push_back(addr_row(16'hFFFF, 1'b1, 15'h01FF, 7'd1, 1'b0, 1'b1));
        directed_rows.push_back(addr_row(16'h00FF, 1'b1, 15'h00FF, 7'd0, 1'b1, 1'b0));
        directed_rows.push_back(addr_row(16'hFF00, 1'b1, 15'h0100, 7'd1, 1'b1, 1'b0));
        directed_rows.push_back(addr_row(16'hAAAA, 1'b1, 15'h02AA, 7'd2, 1'b0, 1'b1));
        directed_rows.push_back(addr_row(16'h5555, 1'b1, 15'h0355, 7'd3, 1'b0, 1'b1));
        // Fourteen new pages fill the TLB and wrap the refill pointer, which
        // evicts the entries for pages 0x00 and 0xFF.
        for (int k = 0; k < 14; k++) begin
            directed_rows.push_back(addr_row({8'(8'h10 + k), 8'h3C}, 1'b0, '0, '0, 1'b0, 1'b0));
        end
        // Evicted pages come back from the page table, page 0x00 then hits in the TLB, and 0x80 is new.
        directed_rows.push_back(addr_row(16'h0012, 1'b0, '0, '0, 1'b0, 1'b0));
        directed_rows.push_back(addr_row(16'h00ED, 1'b0, '0, '0, 1'b0, 1'b0));
        directed_rows.push_back(addr_row(16'hFF80, 1'b0, '0, '0, 1'b0, 1'b0));
        directed_rows.push_back(addr_row(16'hAA01, 1'b0, '0, '0, 1'b0, 1'b0));
        directed_rows.push_back(addr_row(16'h8000, 1'b0, '0, '0, 1'b0, 1'b0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The block ignores the input during its clearing pass; the first
        // offer simply waits for ready.
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            offer_address(directed_rows[r].va, directed_rows[r].fixed, directed_rows[r].result);
        end

        // Random part. Most addresses come from a small working set of pages
        // that is replaced every thirty items, which gives TLB hits, refills
        // with eviction, page table hits and a steady stream of new pages.
        // The new pages use up the frame pool partway through, after which
        // faults report exhaustion. The rest are fully random addresses.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 30 == 0) begin
                hot_count = $urandom_range(4, 24);
                for (int h = 0; h < hot_count; h++) hot_pages[h] = 8'($urandom_range(0, 255));
            end
            if (n == DRAIN_AT) drain_results();
            if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
            if ($urandom_range(0, 9) < 8) begin
                va = {hot_pages[$urandom_range(0, hot_count - 1)], 8'($urandom_range(0, 255))};
            end else begin
                va = VA_W'($urandom_range(0, 65535));
            end
            offer_address(va, 1'b0, '0);
        end

        drain_results();
        // Give a stray extra result time to show up before closing.
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && pending_xlat.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
